// ===== hw/rtl/fct_pkg.sv =====
// Package with the shared sizes, status codes and entry type of the flow counter table.
package fct_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam logic [15:0] LISTEN_PORT_RESET = 16'd12345;
    localparam logic [31:0] COUNT_MAX         = 32'hFFFF_FFFF;

    localparam logic [2:0] ST_IGNORED       = 3'd0;
    localparam logic [2:0] ST_COUNTED       = 3'd1;
    localparam logic [2:0] ST_NEW           = 3'd2;
    localparam logic [2:0] ST_FULL          = 3'd3;
    localparam logic [2:0] ST_CLOSED        = 3'd4;
    localparam logic [2:0] ST_CLOSE_UNKNOWN = 3'd5;

    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_CLOSE = 1'b1;

    typedef struct packed {
        logic [31:0] addr;
        logic [15:0] port;
        logic [31:0] count;
    } entry_t;

endpackage

// ===== hw/rtl/fct_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fct_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      clk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== hw/rtl/flow_counter_table.sv =====
// Top level of the flow counter table: search, update and compaction sequencer over one RAM.
//
// Usage: an item (command, source_addr, source_port, dest_port) is taken at a rising
// clock edge where start is high and busy is low. Exactly one result comes back per
// item on status, message_count and live_flows, marked by result_valid for exactly one
// cycle; the receiver cannot stall, so it must take the result in that cycle.
// live_flows always shows the current number of stored flows.
//
// Timing: an item whose dest_port differs from listen_port gives its result in the
// cycle after it is taken. Otherwise the block walks the table one entry per cycle
// through the single RAM read port until it finds the flow or passes the last stored
// flow. A close then moves each later entry down one slot, one entry per cycle. Busy
// stays high for the whole walk, and the next item can be taken at the edge that ends
// the result cycle.
//
// Configuration: listen_port is written over cfg_valid / cfg_ready / cfg_data, which is
// always ready; it should only be written while no item is in progress.
//
// Reset (rst_n low, asynchronous) empties the table at once by clearing the live count
// and sets listen_port to 12345. The RAM contents are not cleared: only slots below the
// live count are ever used, and each of those has been written.
module flow_counter_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        command,
    input  logic [31:0] source_addr,
    input  logic [15:0] source_port,
    input  logic [15:0] dest_port,
    output logic        result_valid,
    output logic [2:0]  status,
    output logic [31:0] message_count,
    output logic [7:0]  live_flows,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);

    localparam int CNT_W = fct_pkg::CNT_W;
    localparam int IDX_W = fct_pkg::IDX_W;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] live_reg, live_next;
    logic [15:0]      listen_reg;

    // Key of the item in progress.
    logic             cmd_reg, cmd_next;
    logic [31:0]      key_addr_reg, key_addr_next;
    logic [15:0]      key_port_reg, key_port_next;

    // Result register.
    logic             valid_reg, valid_next;
    logic [2:0]       status_reg, status_next;
    logic [31:0]      count_reg, count_next;

    // RAM port signals.
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    fct_pkg::entry_t  wr_data;
    logic [IDX_W-1:0] rd_addr;
    fct_pkg::entry_t  rd_data;

    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_inc2;
    logic [CNT_W-1:0] rd_idx;
    logic             hit;

    fct_ram #(
        .WIDTH ($bits(fct_pkg::entry_t)),
        .DEPTH (fct_pkg::TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign idx_inc  = idx_reg + CNT_W'(1);
    assign idx_inc2 = idx_reg + CNT_W'(2);

    // The entry on rd_data belongs to slot idx_reg while searching.
    assign hit = (idx_reg < live_reg) && (rd_data.addr == key_addr_reg)
                 && (rd_data.port == key_port_reg);

    assign rd_addr = rd_idx[IDX_W-1:0];

    always_comb
    begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        live_next     = live_reg;
        cmd_next      = cmd_reg;
        key_addr_next = key_addr_reg;
        key_port_next = key_port_reg;
        valid_next    = 1'b0;
        status_next   = status_reg;
        count_next    = count_reg;
        rd_idx        = idx_inc;
        wr_en         = 1'b0;
        wr_addr       = idx_reg[IDX_W-1:0];
        wr_data       = rd_data;

        unique case (state_reg)
            S_IDLE:
            begin
                rd_idx = '0;
                if (start)
                begin
                    cmd_next      = command;
                    key_addr_next = source_addr;
                    key_port_next = source_port;
                    if (dest_port != listen_reg)
                    begin
                        valid_next  = 1'b1;
                        status_next = fct_pkg::ST_IGNORED;
                        count_next  = '0;
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                if (hit)
                begin
                    if (cmd_reg == fct_pkg::CMD_DATA)
                    begin
                        wr_en = 1'b1;
                        if (rd_data.count != fct_pkg::COUNT_MAX)
                        begin
                            wr_data.count = rd_data.count + 32'd1;
                        end
                        valid_next  = 1'b1;
                        status_next = fct_pkg::ST_COUNTED;
                        count_next  = wr_data.count;
                        state_next  = S_IDLE;
                    end
                    else if (idx_inc >= live_reg)
                    begin
                        live_next   = live_reg - CNT_W'(1);
                        valid_next  = 1'b1;
                        status_next = fct_pkg::ST_CLOSED;
                        count_next  = '0;
                        state_next  = S_IDLE;
                    end
                    else
                    begin
                        // The read of the next slot is already under way.
                        state_next = S_SHIFT;
                    end
                end
                else if (idx_inc < live_reg)
                begin
                    idx_next = idx_inc;
                end
                else
                begin
                    valid_next = 1'b1;
                    count_next = '0;
                    state_next = S_IDLE;
                    if (cmd_reg == fct_pkg::CMD_CLOSE)
                    begin
                        status_next = fct_pkg::ST_CLOSE_UNKNOWN;
                    end
                    else if (live_reg < CNT_W'(fct_pkg::TABLE_DEPTH))
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = live_reg[IDX_W-1:0];
                        wr_data.addr  = key_addr_reg;
                        wr_data.port  = key_port_reg;
                        wr_data.count = 32'd1;
                        live_next     = live_reg + CNT_W'(1);
                        status_next   = fct_pkg::ST_NEW;
                        count_next    = 32'd1;
                    end
                    else
                    begin
                        status_next = fct_pkg::ST_FULL;
                    end
                end
            end

            S_SHIFT:
            begin
                // rd_data holds slot idx_reg + 1; move it down into idx_reg.
                wr_en    = 1'b1;
                rd_idx   = idx_inc2;
                idx_next = idx_inc;
                if (idx_inc2 >= live_reg)
                begin
                    live_next   = live_reg - CNT_W'(1);
                    valid_next  = 1'b1;
                    status_next = fct_pkg::ST_CLOSED;
                    count_next  = '0;
                    state_next  = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            idx_reg    <= '0;
            live_reg   <= '0;
            valid_reg  <= 1'b0;
            listen_reg <= fct_pkg::LISTEN_PORT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            live_reg  <= live_next;
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
            begin
                listen_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        key_addr_reg <= key_addr_next;
        key_port_reg <= key_port_next;
        status_reg   <= status_next;
        count_reg    <= count_next;
    end

    assign busy          = (state_reg != S_IDLE);
    assign cfg_ready     = 1'b1;
    assign result_valid  = valid_reg;
    assign status        = status_reg;
    assign message_count = count_reg;
    assign live_flows    = 8'(live_reg);

endmodule

// ===== hw/rtl/fct_checker.sv =====
// Port-level checker for the flow counter table and its bind to the top level.
module fct_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        result_valid,
    input logic [2:0]  status,
    input logic [31:0] message_count,
    input logic [7:0]  live_flows
);

    // An accepted item either answers at once or keeps the block busy.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (result_valid || busy))
        else $error("accepted item neither answered nor started a search");

    // Only counted and new-entry results carry a count, and it is never zero.
    a_count_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status != fct_pkg::ST_COUNTED && status != fct_pkg::ST_NEW)
        |-> (message_count == 32'd0))
        else $error("count reported for a result without a reply");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (status == fct_pkg::ST_COUNTED || status == fct_pkg::ST_NEW))
        |-> (message_count != 32'd0))
        else $error("zero count on a counted or new flow");

    // The live count moves only together with a result.
    a_live_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> $stable(live_flows))
        else $error("live flow count changed without a result");

    // A new entry grows the table by exactly one.
    a_new_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && status == fct_pkg::ST_NEW)
        |-> (live_flows == 8'($past(live_flows) + 8'd1)))
        else $error("new entry did not grow the table by one");

endmodule

bind flow_counter_table fct_checker u_fct_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .result_valid  (result_valid),
    .status        (status),
    .message_count (message_count),
    .live_flows    (live_flows)
);

// ===== verif/tb.sv =====
// Self-checking testbench for the flow counter table: directed and random items, checked per result.
`timescale 1ns / 1ps

module tb;

    // Run length guard and the settle time after the last result. The slowest item
    // walks the whole table or compacts it.
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int DRAIN_CYCLES = 2 * fct_pkg::TABLE_DEPTH + 40;
    localparam int KEY_POOL     = 256;

    typedef struct {
        logic        command;
        logic [31:0] addr;
        logic [15:0] sport;
        logic [15:0] dport;
    } msg_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] count;
        logic [7:0]  live;
    } reply_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        command;
    logic [31:0] source_addr;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic        result_valid;
    logic [2:0]  status;
    logic [31:0] message_count;
    logic [7:0]  live_flows;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;

    // Items waiting to be sent, and the replies the table owes for items it has taken.
    msg_t   pending_msgs[$];
    reply_t awaited_replies[$];

    // Our own copy of the flow table, kept packed in slots 0 .. flows_live-1.
    logic [31:0] flow_addr[fct_pkg::TABLE_DEPTH];
    logic [15:0] flow_port[fct_pkg::TABLE_DEPTH];
    logic [31:0] flow_hits[fct_pkg::TABLE_DEPTH];
    int          flows_live;
    logic [15:0] match_port;

    // Flow keys that the random traffic draws from.
    logic [31:0] key_addr[KEY_POOL];
    logic [15:0] key_port[KEY_POOL];

    int     send_idle_pct;
    bit     item_taken;
    msg_t   next_msg;
    msg_t   seen_msg;
    reply_t want;
    int     mismatches;
    int     items_taken;
    int     peak_live;
    int     cycle_count;
    int     status_tally[6];

    flow_counter_table u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .command       (command),
        .source_addr   (source_addr),
        .source_port   (source_port),
        .dest_port     (dest_port),
        .result_valid  (result_valid),
        .status        (status),
        .message_count (message_count),
        .live_flows    (live_flows),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #10 clk = ~clk;

    // Works out the reply to one message and updates our copy of the table. Only
    // messages aimed at the listen port touch the table; a close removes the flow
    // and slides every later entry down one slot, so the table stays packed.
    function automatic reply_t predict_flow(msg_t m);
        reply_t r;
        int     slot;
        r.status = fct_pkg::ST_IGNORED;
        r.count  = '0;
        slot     = -1;
        if (m.dport == match_port)
        begin
            for (int k = 0; k < flows_live; k++)
            begin
                if (slot < 0 && flow_addr[k] == m.addr && flow_port[k] == m.sport)
                    slot = k;
            end
            if (m.command == fct_pkg::CMD_CLOSE)
            begin
                if (slot >= 0)
                begin
                    for (int k = slot; k < flows_live - 1; k++)
                    begin
                        flow_addr[k] = flow_addr[k + 1];
                        flow_port[k] = flow_port[k + 1];
                        flow_hits[k] = flow_hits[k + 1];
                    end
                    flows_live--;
                    r.status = fct_pkg::ST_CLOSED;
                end
                else
                begin
                    r.status = fct_pkg::ST_CLOSE_UNKNOWN;
                end
            end
            else if (slot >= 0)
            begin
                // Counters stick at the top instead of wrapping.
                if (flow_hits[slot] != fct_pkg::COUNT_MAX)
                    flow_hits[slot] = flow_hits[slot] + 1;
                r.count  = flow_hits[slot];
                r.status = fct_pkg::ST_COUNTED;
            end
            else if (flows_live < fct_pkg::TABLE_DEPTH)
            begin
                flow_addr[flows_live] = m.addr;
                flow_port[flows_live] = m.sport;
                flow_hits[flows_live] = 32'd1;
                flows_live++;
                r.count  = 32'd1;
                r.status = fct_pkg::ST_NEW;
            end
            else
            begin
                r.status = fct_pkg::ST_FULL;
            end
        end
        if (flows_live > peak_live)
            peak_live = flows_live;
        r.live = 8'(flows_live);
        return r;
    endfunction

    function automatic void queue_msg(logic cmd, logic [31:0] a, logic [15:0] sp,
                                      logic [15:0] dp);
        msg_t m;
        m.command = cmd;
        m.addr    = a;
        m.sport   = sp;
        m.dport   = dp;
        pending_msgs.push_back(m);
    endfunction

    // Random traffic for one phase. Most messages use keys from the first pool_n
    // entries of the pool, so flows recur, get counted and get closed; the rest are
    // aimed at some other port with a random command (half with a random key); they must be ignored.
    task automatic add_traffic(logic [15:0] port, int n, int pool_n, int close_pct,
                               int ignore_pct);
        msg_t m;
        int   pick;
        int   roll;
        for (int i = 0; i < n; i++)
        begin
            roll      = $urandom_range(99);
            pick      = $urandom_range(pool_n - 1);
            m.addr    = key_addr[pick];
            m.sport   = key_port[pick];
            m.dport   = port;
            m.command = (roll < close_pct) ? fct_pkg::CMD_CLOSE : fct_pkg::CMD_DATA;
            if (roll >= 100 - ignore_pct)
            begin
                m.command = 1'($urandom_range(1));
                if ($urandom_range(1) == 1)
                begin
                    m.addr  = $urandom;
                    m.sport = 16'($urandom);
                end
                do
                    m.dport = 16'($urandom);
                while (m.dport == port);
            end
            pending_msgs.push_back(m);
        end
    endtask

    // The listen port is only changed while the table has nothing in progress.
    task automatic write_listen_port(logic [15:0] value);
        @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Returns once every queued item has been sent and answered and the block is idle.
    task automatic wait_idle();
        do
            @(posedge clk);
        while (pending_msgs.size() != 0 || start || busy || awaited_replies.size() != 0);
    endtask

    // Driver: inputs change on the falling edge. A presented item is held until the
    // rising edge that takes it; while the line is idle the fields carry random junk.
    always @(negedge clk)
    begin
        if (rst_n && (!start || item_taken))
        begin
            if (pending_msgs.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                next_msg    = pending_msgs.pop_front();
                command     <= next_msg.command;
                source_addr <= next_msg.addr;
                source_port <= next_msg.sport;
                dest_port   <= next_msg.dport;
                start       <= 1'b1;
            end
            else
            begin
                command     <= 1'($urandom_range(1));
                source_addr <= $urandom;
                source_port <= 16'($urandom);
                dest_port   <= 16'($urandom);
                start       <= 1'b0;
            end
        end
        item_taken = 1'b0;
    end

    // Monitor: on each rising edge, check a result against the oldest awaited reply,
    // track listen port writes, and predict the reply of any item taken at this edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid)
            begin
                if (awaited_replies.size() == 0)
                begin
                    $display("%0t: result with none awaited: status %0d count %0d live %0d",
                             $time, status, message_count, live_flows);
                    mismatches++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, status);
                        mismatches++;
                    end
                    if (message_count !== want.count)
                    begin
                        $display("%0t: message_count expected %0d actual %0d",
                                 $time, want.count, message_count);
                        mismatches++;
                    end
                    if (live_flows !== want.live)
                    begin
                        $display("%0t: live_flows expected %0d actual %0d",
                                 $time, want.live, live_flows);
                        mismatches++;
                    end
                end
                if (status <= fct_pkg::ST_CLOSE_UNKNOWN)
                    status_tally[status]++;
            end
            if (cfg_valid && cfg_ready)
                match_port = cfg_data;
            if (start && !busy)
            begin
                seen_msg.command = command;
                seen_msg.addr    = source_addr;
                seen_msg.sport   = source_port;
                seen_msg.dport   = dest_port;
                awaited_replies.push_back(predict_flow(seen_msg));
                item_taken = 1'b1;
                items_taken++;
            end
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] mid_port;
        rst_n       = 1'b0;
        start       = 1'b0;
        command     = fct_pkg::CMD_DATA;
        source_addr = '0;
        source_port = '0;
        dest_port   = '0;
        cfg_valid   = 1'b0;
        cfg_data    = '0;
        flows_live  = 0;
        match_port  = fct_pkg::LISTEN_PORT_RESET;
        send_idle_pct = 34;

        // Key pool: the all-zero and all-one keys first, then random keys where every
        // fourth one shares its address with the one before, so a lookup has to
        // compare the port as well.
        for (int i = 0; i < KEY_POOL; i++)
        begin
            if (i == 0)
            begin
                key_addr[i] = '0;
                key_port[i] = '0;
            end
            else if (i == 1)
            begin
                key_addr[i] = '1;
                key_port[i] = '1;
            end
            else
            begin
                key_addr[i] = (i % 4 == 3) ? key_addr[i - 1] : $urandom;
                key_port[i] = 16'($urandom);
            end
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part on the listen port left by reset. It starts with the wrong
        // port and a close on the empty table, then builds four flows whose keys
        // differ only in address or only in port, closes the first one so the rest
        // must slide down, closes a flow twice, closes the last slot, and checks
        // that a close aimed at another port is ignored.
        queue_msg(fct_pkg::CMD_DATA,  32'h0000_0000, 16'h0000, 16'h0000);
        queue_msg(fct_pkg::CMD_DATA,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF);
        queue_msg(fct_pkg::CMD_CLOSE, 32'h0000_0000, 16'h0000, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'h0000_0000, 16'h0000, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'h0000_0000, 16'h0000, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'hFFFF_FFFF, 16'hFFFF, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'hFFFF_FFFF, 16'hFFFF, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'h0000_0000, 16'hFFFF, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'hFFFF_FFFF, 16'h0000, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_CLOSE, 32'h0000_0000, 16'h0000, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_CLOSE, 32'h0000_0000, 16'h0000, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'hFFFF_FFFF, 16'hFFFF, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_CLOSE, 32'hFFFF_FFFF, 16'h0000, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'h0000_0000, 16'h0000, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_CLOSE, 32'hFFFF_FFFF, 16'hFFFF,
                  fct_pkg::LISTEN_PORT_RESET - 16'd1);
        queue_msg(fct_pkg::CMD_CLOSE, 32'hFFFF_FFFF, 16'hFFFF, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'h0000_0000, 16'hFFFF, fct_pkg::LISTEN_PORT_RESET);
        queue_msg(fct_pkg::CMD_DATA,  32'h0000_0000, 16'hFFFF, fct_pkg::LISTEN_PORT_RESET);
        wait_idle();

        // Listen port zero, mostly new flows from a wide key pool: the table fills
        // up and later unknown flows get dropped.
        write_listen_port(16'h0000);
        add_traffic(16'h0000, 600, 220, 6, 6);
        wait_idle();

        // Listen port all ones, many closes: deep lookups with long compaction walks.
        send_idle_pct = 58;
        write_listen_port(16'hFFFF);
        add_traffic(16'hFFFF, 600, 220, 45, 8);
        wait_idle();

        // A random listen port, a small key pool and back-to-back items: counters
        // climb while the leftover flows from before make every miss a long search.
        send_idle_pct = 0;
        mid_port = 16'($urandom_range(65534, 1));
        write_listen_port(mid_port);
        add_traffic(mid_port, 680, 24, 30, 10);
        wait_idle();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (awaited_replies.size() != 0)
        begin
            $display("%0t: %0d replies never arrived", $time, awaited_replies.size());
            mismatches++;
        end

        $display("tb: %0d items over four listen ports, table peaked at %0d flows",
                 items_taken, peak_live);
        $display("tb: ignored %0d, counted %0d, new %0d, full %0d, closed %0d, unknown %0d",
                 status_tally[0], status_tally[1], status_tally[2], status_tally[3],
                 status_tally[4], status_tally[5]);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
